FILE: rtl/mesh_vertex_normals_defines.svh
// Assertion macros shared by the mesh vertex normal RTL.
`ifndef MESH_VERTEX_NORMALS_DEFINES_SVH
`define MESH_VERTEX_NORMALS_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MVN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mvn_pkg.sv
// Shared types and constants for the mesh vertex normal block.
package mvn_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int ONE_Q14 = 16384;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_FIN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_VWAIT,
    S_EDGE,
    S_MUL,
    S_MULW,
    S_TGO,
    S_TWAIT,
    S_ARD,
    S_AWR,
    S_FRD,
    S_FGO,
    S_FWAIT,
    S_FOUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_SQRT,
    U_DSET,
    U_DIV,
    U_CLAMP,
    U_DONE
  } norm_state_t;

  typedef struct packed {
    logic take;
    logic vtx_wr;
    logic vrd;
    logic edge_en;
    logic seq_clr;
    logic seq_inc;
    logic mul_en;
    logic norm_go;
    logic norm_src_acc;
    logic acc_rd;
    logic acc_rd_idx;
    logic acc_wr;
    logic acc_clear;
    logic idx_clr;
    logic idx_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t        op;
    logic       slot_ok;
    logic       tri_ok;
    logic       cnt_zero;
    logic [2:0] seq;
    logic       norm_done;
    logic       norm_busy;
    logic       out_free;
    logic       idx_last;
  } stat_t;

endpackage

FILE: rtl/mvn_ram.sv
// Generic single write port RAM with registered read.
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mvn_norm.sv
// Iterative vector normalizer: shift search, sum of squares, square root, divide.
`include "mesh_vertex_normals_defines.svh"
module mvn_norm
  import mvn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] vec [3],
  output logic               busy,
  output logic               done,
  output logic signed [15:0] n [3]
);

  norm_state_t state, state_next;

  logic [33:0] mag [3];
  logic [2:0]  neg;
  logic [41:0] sq;
  logic [41:0] r;
  logic [4:0]  step;
  logic [1:0]  ci;
  logic [20:0] rem;
  logic [16:0] lo;
  logic [16:0] q;

  logic [33:0] m;
  logic [34:0] avec [3];
  logic [41:0] bitv;
  logic [41:0] trial;
  logic [34:0] num;
  logic [21:0] dtr;
  logic        ge;
  logic [14:0] qc;
  logic [20:0] len;
  logic        n_ok;

  assign len = r[20:0];

  always_comb begin
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    for (int i = 0; i < 3; i++) begin
      avec[i] = vec[i][34] ? 35'(-vec[i]) : vec[i];
    end
    bitv  = 42'(1) << {step, 1'b0};
    trial = r + bitv;
    num   = {1'b0, mag[ci][19:0], 14'd0} + 35'(len >> 1);
    dtr   = {rem, lo[16]};
    ge    = dtr >= {1'b0, len};
    qc    = (q > 17'(ONE_Q14)) ? 15'(ONE_Q14) : q[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE:  if (start) state_next = U_SHIFT;
      U_SHIFT: begin
        if (m == '0) state_next = U_DONE;
        else if (m[33:20] == '0 && m[19]) state_next = U_SQ;
      end
      U_SQ:    if (step == 5'd2) state_next = U_SQRT;
      U_SQRT:  if (step == 5'd0) state_next = U_DSET;
      U_DSET:  state_next = U_DIV;
      U_DIV:   if (step == 5'd0) state_next = U_CLAMP;
      U_CLAMP: state_next = (ci == 2'd2) ? U_DONE : U_DSET;
      U_DONE:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= avec[i][33:0];
            neg[i] <= vec[i][34];
          end
        end
      end
      U_SHIFT: begin
        if (m == '0) begin
          for (int i = 0; i < 3; i++) n[i] <= '0;
        end else if (m[33:20] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!m[19]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end else begin
          sq   <= '0;
          step <= '0;
        end
      end
      U_SQ: begin
        sq <= sq + 42'(mag[step[1:0]][19:0] * mag[step[1:0]][19:0]);
        if (step == 5'd2) begin
          r    <= '0;
          step <= 5'd20;
        end else begin
          step <= step + 5'd1;
        end
      end
      U_SQRT: begin
        if (sq >= trial) begin
          sq <= sq - trial;
          r  <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        if (step == 5'd0) ci <= '0;
        else step <= step - 5'd1;
      end
      U_DSET: begin
        rem  <= {3'd0, num[34:17]};
        lo   <= num[16:0];
        q    <= '0;
        step <= 5'd16;
      end
      U_DIV: begin
        rem  <= ge ? 21'(dtr - {1'b0, len}) : dtr[20:0];
        lo   <= lo << 1;
        q    <= {q[15:0], ge};
        step <= step - 5'd1;
      end
      U_CLAMP: begin
        n[ci] <= neg[ci] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        ci    <= ci + 2'd1;
      end
      default: ;
    endcase
  end

  assign busy = (state != U_IDLE);
  assign done = (state == U_DONE);

  assign n_ok = (n[0] <= 16'sd16384) && (n[0] >= -16'sd16384) && (n[1] <= 16'sd16384)
                && (n[1] >= -16'sd16384) && (n[2] <= 16'sd16384) && (n[2] >= -16'sd16384);

  `MVN_ASSERT(a_norm_range, done |-> n_ok, "normal component out of unit range")
  `MVN_ASSERT(a_norm_start, start |-> !busy, "normalizer started while busy")

endmodule

FILE: rtl/mvn_datapath.sv
// Datapath: vertex store, cross product, accumulators, output register.
module mvn_datapath
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic [1:0]         opcode,
  input  logic [5:0]         vertex_slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [5:0]         corner_a,
  input  logic [5:0]         corner_b,
  input  logic [5:0]         corner_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         normal_slot,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               last_normal
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  function automatic logic signed [23:0] sat_add(logic signed [23:0] a, logic signed [15:0] b);
    logic signed [24:0] s;
    s = $signed({a[23], a}) + $signed({{9{b[15]}}, b});
    if (s > 25'sd8388607) return 24'sh7FFFFF;
    if (s < -25'sd8388608) return 24'sh800000;
    return s[23:0];
  endfunction

  logic [6:0]      vertex_count;
  logic [CNTW-1:0] cnt_eff;
  logic [AW-1:0]   ca, cb, cc, csel;
  logic [2:0]      seq;
  logic [AW-1:0]   idx;

  logic [47:0]        vram_rdata;
  logic               vrd_q;
  logic [1:0]         vsel_q;
  logic signed [15:0] vreg [3][3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic [2:0]         prod_sel;
  logic               prod_vld;
  logic signed [34:0] cr [3];

  logic [71:0]            acc_rdata, acc_wdata;
  logic [AW-1:0]          acc_raddr;
  logic [MAX_VERTICES-1:0] acc_vld;
  logic                   acc_vld_q;
  logic signed [23:0]     acc_base [3];

  logic               nrm_busy, nrm_done;
  logic signed [34:0] nvec [3];
  logic signed [15:0] nrm [3];

  // config register and effective count
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign cnt_eff = (vertex_count > 7'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES)
                                                   : CNTW'(vertex_count);

  always_comb begin
    st.op        = op_t'(opcode);
    st.slot_ok   = {1'b0, vertex_slot} < 7'(MAX_VERTICES);
    st.tri_ok    = ({1'b0, corner_a} < 7'(cnt_eff)) && ({1'b0, corner_b} < 7'(cnt_eff))
                   && ({1'b0, corner_c} < 7'(cnt_eff));
    st.cnt_zero  = (cnt_eff == '0);
    st.seq       = seq;
    st.norm_done = nrm_done;
    st.norm_busy = nrm_busy;
    st.out_free  = !out_valid || !out_stall;
    st.idx_last  = (CNTW'(idx) + CNTW'(1)) == cnt_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ca <= corner_a[AW-1:0];
      cb <= corner_b[AW-1:0];
      cc <= corner_c[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
      idx <= '0;
    end else begin
      if (cmd.seq_clr) seq <= '0;
      else if (cmd.seq_inc) seq <= seq + 3'd1;
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + AW'(1);
    end
  end

  always_comb begin
    case (seq)
      3'd0:    csel = ca;
      3'd1:    csel = cb;
      default: csel = cc;
    endcase
  end

  // vertex store
  mvn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (cmd.vtx_wr),
    .waddr (vertex_slot[AW-1:0]),
    .wdata ({coord_z, coord_y, coord_x}),
    .re    (cmd.vrd),
    .raddr (csel),
    .rdata (vram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vrd_q <= 1'b0;
    end else begin
      vrd_q <= cmd.vrd;
    end
  end

  always_ff @(posedge clk) begin
    vsel_q <= seq[1:0];
    if (vrd_q) begin
      for (int i = 0; i < 3; i++) vreg[vsel_q][i] <= vram_rdata[16*i +: 16];
    end
    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= $signed({vreg[1][i][15], vreg[1][i]}) - $signed({vreg[0][i][15], vreg[0][i]});
        e2[i] <= $signed({vreg[2][i][15], vreg[2][i]}) - $signed({vreg[0][i][15], vreg[0][i]});
      end
    end
  end

  // cross product: one product per cycle
  always_comb begin
    case (seq)
      3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_sel <= seq;
    if (prod_vld) begin
      if (!prod_sel[0]) cr[prod_sel[2:1]] <= 35'(prod);
      else cr[prod_sel[2:1]] <= cr[prod_sel[2:1]] - 35'(prod);
    end
  end

  // accumulators
  assign acc_raddr = cmd.acc_rd_idx ? idx : csel;

  mvn_ram #(.WIDTH(72), .DEPTH(MAX_VERTICES)) u_acc (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (csel),
    .wdata (acc_wdata),
    .re    (cmd.acc_rd),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      acc_vld <= '0;
    end else if (cmd.acc_wr) begin
      acc_vld[csel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_rd) acc_vld_q <= acc_vld[acc_raddr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_base[i] = acc_vld_q ? acc_rdata[24*i +: 24] : 24'sd0;
      nvec[i]     = cmd.norm_src_acc ? 35'(acc_base[i]) : cr[i];
    end
    acc_wdata = {sat_add(acc_base[2], nrm[2]), sat_add(acc_base[1], nrm[1]),
                 sat_add(acc_base[0], nrm[0])};
  end

  mvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_go),
    .vec   (nvec),
    .busy  (nrm_busy),
    .done  (nrm_done),
    .n     (nrm)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normal_slot <= 6'(idx);
      normal_x    <= nrm[0];
      normal_y    <= nrm[1];
      normal_z    <= nrm[2];
      last_normal <= st.idx_last;
    end
  end

endmodule

FILE: rtl/mvn_ctrl.sv
// Controller state machine sequencing loads, triangles and finish runs.
`include "mesh_vertex_normals_defines.svh"
module mvn_ctrl
  import mvn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (st.op)
            OP_LOAD: cmd.vtx_wr = st.slot_ok;
            OP_TRI: begin
              if (st.tri_ok) begin
                cmd.seq_clr = 1'b1;
                state_next  = S_RD;
              end
            end
            OP_FIN: begin
              if (st.cnt_zero) begin
                cmd.acc_clear = 1'b1;
              end else begin
                cmd.idx_clr = 1'b1;
                state_next  = S_FRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.vrd = 1'b1;
        if (st.seq == 3'd2) begin
          cmd.seq_clr = 1'b1;
          state_next  = S_VWAIT;
        end else begin
          cmd.seq_inc = 1'b1;
        end
      end
      S_VWAIT: state_next = S_EDGE;
      S_EDGE: begin
        cmd.edge_en = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (st.seq == 3'd5) begin
          cmd.seq_clr = 1'b1;
          state_next  = S_MULW;
        end else begin
          cmd.seq_inc = 1'b1;
        end
      end
      S_MULW: state_next = S_TGO;
      S_TGO: begin
        cmd.norm_go = 1'b1;
        state_next  = S_TWAIT;
      end
      S_TWAIT: if (st.norm_done) state_next = S_ARD;
      S_ARD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_AWR;
      end
      S_AWR: begin
        cmd.acc_wr = 1'b1;
        if (st.seq == 3'd2) begin
          state_next = S_IDLE;
        end else begin
          cmd.seq_inc = 1'b1;
          state_next  = S_ARD;
        end
      end
      S_FRD: begin
        cmd.acc_rd     = 1'b1;
        cmd.acc_rd_idx = 1'b1;
        state_next     = S_FGO;
      end
      S_FGO: begin
        cmd.norm_go      = 1'b1;
        cmd.norm_src_acc = 1'b1;
        state_next       = S_FWAIT;
      end
      S_FWAIT: if (st.norm_done) state_next = S_FOUT;
      S_FOUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.idx_last) begin
            cmd.acc_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_FRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `MVN_ASSERT(a_out_free, cmd.out_load |-> st.out_free, "output loaded over a pending request")
  `MVN_ASSERT(a_go_idle, cmd.norm_go |-> !st.norm_busy, "normalizer started while busy")
  `MVN_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE), "controller not idle after reset")

endmodule

FILE: rtl/mesh_vertex_normals.sv
// Top level: per-vertex normals accumulated from unit face normals.
//
//  channel | direction | handshake        | payload
//  cfg     | in        | cfg_wr_en        | cfg_wr_data (vertex_count)
//  in      | in        | in_valid/stall   | opcode, vertex_slot, coord_*, corner_*
//  out     | out       | out_valid/stall  | normal_slot, normal_*, last_normal
//
// A load or skipped triangle is taken in the idle state. A triangle or a finish run holds
// in_stall high, a finish run also through output stalls; a zero vector skips the square
// root and divide. The normalizer does a shift search (up to 19 steps), a bit-serial square
// root (21 steps) and a restoring divider (17 steps per component).
// One request is worked at a time; in_stall is high while it is in progress.
// Reset clears the accumulator valid bits at once; no clearing pass.
// A stalled output holds the finish run before the next vertex is loaded.
module mesh_vertex_normals
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [5:0]         vertex_slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [5:0]         corner_a,
  input  logic [5:0]         corner_b,
  input  logic [5:0]         corner_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         normal_slot,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               last_normal
);

  cmd_t  cmd;
  stat_t st;

  mvn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mvn_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (opcode),
    .vertex_slot (vertex_slot),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .corner_c    (corner_c),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normal_slot (normal_slot),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .last_normal (last_normal)
  );

endmodule

FILE: tb/tb_mesh_vertex_normals.sv
// Self-checking testbench for mesh_vertex_normals with a scoreboard class.
module tb_mesh_vertex_normals;
  import mvn_pkg::*;

  localparam int NV = 64;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [5:0]         slot;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               last;
  } vnorm_t;

  class normal_board;
    int          vtx[NV][3];
    int          acc[NV][3];
    int unsigned vcount;
    int          errors;
    vnorm_t      pending_normals[$];

    function new();
      vcount = 0;
      errors = 0;
      foreach (vtx[i, j]) begin
        vtx[i][j] = 0;
        acc[i][j] = 0;
      end
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void unit_vec(input longint v[3], output int n[3]);
      longint unsigned mag[3], m, sq, len, q;
      int rs, ls;
      m = 0;
      sq = 0;
      rs = 0;
      ls = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        n[0] = 0; n[1] = 0; n[2] = 0;
        return;
      end
      while (m >= (64'h1 << 20)) begin m >>= 1; rs++; end
      while (m < (64'h1 << 19)) begin m <<= 1; ls++; end
      for (int i = 0; i < 3; i++) begin
        mag[i] = (mag[i] >> rs) << ls;
        sq += mag[i] * mag[i];
      end
      len = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * ONE_Q14 + len / 2) / len;
        if (q > ONE_Q14) q = ONE_Q14;
        n[i] = v[i] < 0 ? -int'(q) : int'(q);
      end
    endfunction

    function int sat24(int a, int b);
      int s;
      s = a + b;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      return s;
    endfunction

    function int unsigned active();
      return vcount > NV ? NV : vcount;
    endfunction

    function void note(op_t op, int slot, int x, int y, int z, int a, int b, int c);
      longint e1[3], e2[3], cr[3], s[3];
      int n[3];
      int unsigned cnt;
      int crn[3];
      vnorm_t e;
      cnt = active();
      case (op)
        OP_LOAD: begin
          vtx[slot][0] = shortint'(x);
          vtx[slot][1] = shortint'(y);
          vtx[slot][2] = shortint'(z);
        end
        OP_TRI: begin
          if (a < cnt && b < cnt && c < cnt) begin
            for (int i = 0; i < 3; i++) begin
              e1[i] = longint'(vtx[b][i]) - vtx[a][i];
              e2[i] = longint'(vtx[c][i]) - vtx[a][i];
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            unit_vec(cr, n);
            crn[0] = a; crn[1] = b; crn[2] = c;
            for (int k = 0; k < 3; k++)
              for (int i = 0; i < 3; i++)
                acc[crn[k]][i] = sat24(acc[crn[k]][i], n[i]);
          end
        end
        OP_FIN: begin
          for (int v = 0; v < cnt; v++) begin
            for (int i = 0; i < 3; i++) s[i] = acc[v][i];
            unit_vec(s, n);
            e.slot = 6'(v);
            e.nx = 16'(n[0]); e.ny = 16'(n[1]); e.nz = 16'(n[2]);
            e.last = (v + 1 == cnt);
            pending_normals.push_back(e);
          end
          foreach (acc[i, j]) acc[i][j] = 0;
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(logic [5:0] slot, logic signed [15:0] nx, logic signed [15:0] ny,
               logic signed [15:0] nz, logic last);
      vnorm_t e;
      if (pending_normals.size() == 0) begin
        report("unexpected normal, slot", slot, -1);
        return;
      end
      e = pending_normals.pop_front();
      if (slot !== e.slot) report("normal_slot", slot, e.slot);
      if (nx !== e.nx) report("normal_x", nx, e.nx);
      if (ny !== e.ny) report("normal_y", ny, e.ny);
      if (nz !== e.nz) report("normal_z", nz, e.nz);
      if (last !== e.last) report("last_normal", last, e.last);
    endtask
  endclass

  logic               clk = 0;
  logic               rst;
  logic               cfg_wr_en;
  logic [6:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         opcode;
  logic [5:0]         vertex_slot;
  logic signed [15:0] coord_x, coord_y, coord_z;
  logic [5:0]         corner_a, corner_b, corner_c;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         normal_slot;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic               last_normal;

  normal_board board = new();
  bit   calm;
  int   sent;
  int   idle_cycles;
  bit   loaded[NV];

  mesh_vertex_normals uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .vertex_slot(vertex_slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_slot(normal_slot), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .last_normal(last_normal)
  );

  always #1 clk = ~clk;

  function int gap_draw();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task send(op_t op, int slot, int x, int y, int z, int a, int b, int c);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    vertex_slot <= 6'(slot);
    coord_x     <= 16'(x);
    coord_y     <= 16'(y);
    coord_z     <= 16'(z);
    corner_a    <= 6'(a);
    corner_b    <= 6'(b);
    corner_c    <= 6'(c);
    do @(posedge clk); while (in_stall);
    board.note(op, slot, x, y, z, a, b, c);
    if (op == OP_LOAD) loaded[slot] = 1;
    sent++;
  endtask

  task load(int slot, int x, int y, int z);
    send(OP_LOAD, slot, x, y, z, $urandom_range(0, 63), $urandom_range(0, 63),
         $urandom_range(0, 63));
  endtask

  task tri_req(int a, int b, int c);
    send(OP_TRI, $urandom_range(0, 63), $urandom, $urandom, $urandom, a, b, c);
  endtask

  task set_count(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.vcount = v;
  endtask

  // result side stall
  initial begin
    int k;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      k = gap_draw();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check(normal_slot, normal_x, normal_y, normal_z, last_normal);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int cnt, eff, ntri, a, b, c, r;
    int pick[4];
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    opcode      <= OP_NONE;
    vertex_slot <= '0;
    coord_x     <= '0;
    coord_y     <= '0;
    coord_z     <= '0;
    corner_a    <= '0;
    corner_b    <= '0;
    corner_c    <= '0;
    sent = 0;
    calm = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty finish, extremes, degenerate, skipped, unused opcode
    set_count(0);
    send(OP_FIN, 0, 0, 0, 0, 0, 0, 0);
    set_count(3);
    load(0, 0, 0, 0);
    load(1, 32767, -32768, 32767);
    load(2, -32768, 32767, -32768);
    load(63, -1, -1, -1);
    tri_req(0, 1, 2);
    tri_req(2, 1, 0);
    tri_req(0, 0, 1);
    tri_req(1, 1, 1);
    tri_req(0, 1, 63);
    tri_req(63, 0, 1);
    send(OP_NONE, 63, -1, -1, -1, 63, 63, 63);
    send(OP_FIN, 0, 0, 0, 0, 0, 0, 0);
    load(0, 4096, 0, 0);
    load(1, 0, 4096, 0);
    load(2, 0, 0, 4096);
    tri_req(0, 1, 2);
    tri_req(0, 2, 1);
    send(OP_FIN, 0, 0, 0, 0, 0, 0, 0);
    set_count(127);
    for (int s = 0; s < NV; s++) load(s, $urandom, $urandom, $urandom);
    for (int t = 0; t < 6; t++)
      tri_req($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
    send(OP_FIN, 0, 0, 0, 0, 0, 0, 0);

    while (sent < 460) begin
      r = $urandom_range(0, 9);
      cnt = r == 0 ? 64 : r == 1 ? 127 : r < 7 ? $urandom_range(3, 12) : $urandom_range(1, 64);
      calm = $urandom_range(0, 4) == 0;
      set_count(cnt);
      eff = cnt > NV ? NV : cnt;
      for (int s = 0; s < eff; s++)
        if (!loaded[s] || $urandom_range(0, 2) == 0) load(s, $urandom, $urandom, $urandom);
      ntri = $urandom_range(4, 20);
      for (int t = 0; t < ntri; t++) begin
        r = $urandom_range(0, 19);
        a = $urandom_range(0, eff - 1);
        b = $urandom_range(0, eff - 1);
        c = $urandom_range(0, eff - 1);
        if (r == 0) send(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        else if (r == 1 && eff < NV) begin
          pick[0] = a; pick[1] = b; pick[2] = c;
          pick[$urandom_range(0, 2)] = $urandom_range(eff, 63);
          tri_req(pick[0], pick[1], pick[2]);
        end else if (r == 2) load(a, $urandom, $urandom, $urandom);
        else if (r == 3) tri_req(a, a, b);
        else tri_req(a, b, c);
      end
      send(OP_FIN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end

    in_valid <= 1'b0;
    while (board.pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.pending_normals.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
